### src/rtc_pkg.sv
// Shared types and constants of the RTP timestamp clock.
`default_nettype none

package rtc_pkg;

   // Field widths
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned RATE_W  = 18;
   localparam int unsigned FRAME_W = 10;
   localparam int unsigned TS_W    = 32;
   localparam int unsigned IDLE_W  = 16;
   localparam int unsigned QUOT_W  = 9;   // rate / 1000 fits in 9 bits

   // Division of an 18-bit rate by 1000: (rate * RECIP_1000) >> RECIP_SHIFT
   localparam int unsigned RECIP_W     = 19;
   localparam int unsigned RECIP_SHIFT = 28;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

   // Operation codes
   localparam logic [2:0] OP_REGISTER   = 3'd0;
   localparam logic [2:0] OP_UNREGISTER = 3'd1;
   localparam logic [2:0] OP_GET_TS     = 3'd2;
   localparam logic [2:0] OP_READ_TS    = 3'd3;
   localparam logic [2:0] OP_TICK       = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_INIT_TS      = 2'd0;
   localparam logic [1:0] CSR_DEFAULT_RATE = 2'd1;
   localparam logic [1:0] CSR_DEFAULT_FRAME = 2'd2;

   // Reset values of the working state and the saturation limit of the idle counter
   localparam logic [TS_W-1:0]    RESET_TS    = 32'd0;
   localparam logic [RATE_W-1:0]  RESET_RATE  = 18'd8000;
   localparam logic [FRAME_W-1:0] RESET_FRAME = 10'd20;
   localparam logic [IDLE_W-1:0]  IDLE_MAX    = 16'hFFFF;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [KEY_W-1:0]   format_key;
      logic [RATE_W-1:0]  sampling_rate;
      logic [FRAME_W-1:0] frame_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [TS_W-1:0]  timestamp;
      logic             time_based;
      logic [KEY_W-1:0] echoed_key;
   } rsp_type;

   // One table entry
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [RATE_W-1:0]  rate;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_item;
      logic       reg_write;
      logic       idx_clear;
      logic       idx_inc;
      logic       rd_issue;
      logic       shift_rd;
      logic       shift_wr;
      logic       count_dec;
      logic       mul_q;
      logic       mul_inc;
      logic       add_time;
      logic       sel_format;
      logic       tick;
      logic       rsp_load;
      logic [1:0] rsp_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [2:0] opcode;
      logic       full;
      logic       scan_end;
      logic       hit;
      logic       key_current;
      logic       shift_end;
   } stat_type;

endpackage

`default_nettype wire

### src/rtc_dpath.sv
// Datapath of the RTP timestamp clock: format table, timestamp arithmetic, result register.
`default_nettype none

module rtc_dpath #(
   parameter int unsigned TABLE_DEPTH        = 8,
   parameter int unsigned IDLE_LIMIT_SECONDS = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rtc_pkg::req_type req_payload,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata,
   input  wire rtc_pkg::cmd_type cmd,
   output rtc_pkg::stat_type     stat,
   output rtc_pkg::rsp_type      rsp_payload
);
   import rtc_pkg::*;

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   // Table memory, one write and one registered read per cycle
   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   req_type            item_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   idx_plus;
   logic [KEY_W-1:0]   cur_key_ff, cur_key_in;
   logic [RATE_W-1:0]  cur_rate_ff, cur_rate_in;
   logic [FRAME_W-1:0] cur_frame_ff, cur_frame_in;
   logic [TS_W-1:0]    rtp_time_ff, rtp_time_in;
   logic [IDLE_W-1:0]  idle_ff, idle_in;
   logic               last_tb_ff, last_tb_in;
   logic [QUOT_W-1:0]  quot_ff;
   logic [TS_W-1:0]    inc_ff;
   logic               tb_ff;
   rsp_type            rsp_ff;

   logic [RATE_W+RECIP_W-1:0]  recip_prod;
   logic [IDLE_W+RATE_W-1:0]   idle_prod;
   logic [FRAME_W+QUOT_W-1:0]  frame_prod;
   logic                       time_based;
   logic [IDX_W-1:0]           wr_addr;
   logic [IDX_W-1:0]           rd_addr;
   entry_type                  wr_data;
   logic                       ts_reply;
   logic                       wr_en;

   assign idx_plus = idx_ff + CNT_W'(1);

   // Status back to the controller
   assign stat.opcode      = item_ff.opcode;
   assign stat.full        = (count_ff == CNT_W'(TABLE_DEPTH));
   assign stat.scan_end    = (idx_ff >= count_ff);
   assign stat.hit         = (rd_data_ff.key == item_ff.format_key);
   assign stat.key_current = (item_ff.format_key == cur_key_ff);
   assign stat.shift_end   = (idx_plus >= count_ff);

   // Input transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
   end

   // Table write and read ports
   assign wr_en   = cmd.reg_write | cmd.shift_wr;
   assign wr_addr = cmd.reg_write ? count_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.reg_write ?
                    entry_type'{key: item_ff.format_key, rate: item_ff.sampling_rate,
                                frame: item_ff.frame_ms} : rd_data_ff;
   assign rd_addr = cmd.shift_rd ? idx_plus[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_issue | cmd.shift_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Timestamp arithmetic: reciprocal division by 1000, then the increment
   assign recip_prod = cur_rate_ff * RECIP_1000;
   assign idle_prod  = idle_ff * cur_rate_ff;
   assign frame_prod = cur_frame_ff * quot_ff;
   assign time_based = (idle_ff > IDLE_W'(IDLE_LIMIT_SECONDS));

   always_ff @(posedge clock) begin
      if (cmd.mul_q) begin
         quot_ff <= recip_prod[RECIP_SHIFT +: QUOT_W];
      end
      if (cmd.mul_inc) begin
         tb_ff  <= time_based;
         inc_ff <= time_based ? idle_prod[TS_W-1:0] : TS_W'(frame_prod);
      end
   end

   // Next state of the control registers
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      cur_key_in   = cur_key_ff;
      cur_rate_in  = cur_rate_ff;
      cur_frame_in = cur_frame_ff;
      rtp_time_in  = rtp_time_ff;
      idle_in      = idle_ff;
      last_tb_in   = last_tb_ff;

      if (cmd.reg_write) count_in = count_ff + CNT_W'(1);
      if (cmd.count_dec) count_in = count_ff - CNT_W'(1);
      if (cmd.idx_clear) idx_in = '0;
      if (cmd.idx_inc)   idx_in = idx_plus;

      if (cmd.add_time) begin
         rtp_time_in = rtp_time_ff + inc_ff;
         idle_in     = '0;
         last_tb_in  = tb_ff;
      end
      if (cmd.sel_format) begin
         cur_key_in   = item_ff.format_key;
         cur_rate_in  = rd_data_ff.rate;
         cur_frame_in = rd_data_ff.frame;
      end
      if (cmd.tick && (idle_ff != IDLE_MAX)) begin
         idle_in = idle_ff + IDLE_W'(1);
      end

      // Configuration writes load the working state at once
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INIT_TS:       rtp_time_in  = csr_wdata;
            CSR_DEFAULT_RATE:  cur_rate_in  = csr_wdata[RATE_W-1:0];
            CSR_DEFAULT_FRAME: cur_frame_in = csr_wdata[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         cur_key_ff   <= '0;
         cur_rate_ff  <= RESET_RATE;
         cur_frame_ff <= RESET_FRAME;
         rtp_time_ff  <= RESET_TS;
         idle_ff      <= '0;
         last_tb_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         cur_key_ff   <= cur_key_in;
         cur_rate_ff  <= cur_rate_in;
         cur_frame_ff <= cur_frame_in;
         rtp_time_ff  <= rtp_time_in;
         idle_ff      <= idle_in;
         last_tb_ff   <= last_tb_in;
      end
   end

   // Result register
   assign ts_reply = (cmd.rsp_status == ST_OK) &&
                     ((item_ff.opcode == OP_GET_TS) || (item_ff.opcode == OP_READ_TS));

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status     <= cmd.rsp_status;
         rsp_ff.timestamp  <= ts_reply ? rtp_time_ff : '0;
         rsp_ff.time_based <= last_tb_ff;
         rsp_ff.echoed_key <= ((cmd.rsp_status == ST_OK) && (item_ff.opcode == OP_REGISTER)) ?
                              item_ff.format_key : '0;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### src/rtc_ctrl.sv
// Controller of the RTP timestamp clock: sequences lookup, shift, advance and reply.
`default_nettype none

module rtc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire rtc_pkg::stat_type stat,
   output rtc_pkg::cmd_type       cmd
);
   import rtc_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SCAN_RD  = 4'd2;
   localparam logic [3:0] S_SCAN_CMP = 4'd3;
   localparam logic [3:0] S_SHIFT_RD = 4'd4;
   localparam logic [3:0] S_SHIFT_WR = 4'd5;
   localparam logic [3:0] S_MUL_Q    = 4'd6;
   localparam logic [3:0] S_MUL_INC  = 4'd7;
   localparam logic [3:0] S_ADD      = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               status_in     = ST_OK;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            unique case (stat.opcode)
               OP_REGISTER: begin
                  if (stat.full) begin
                     status_in = ST_TABLE_FULL;
                  end else begin
                     cmd.reg_write = 1'b1;
                  end
               end
               OP_UNREGISTER: begin
                  cmd.idx_clear = 1'b1;
                  state_in      = S_SCAN_RD;
               end
               OP_GET_TS: begin
                  if (stat.key_current) begin
                     state_in = S_MUL_Q;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_SCAN_RD;
                  end
               end
               OP_TICK: cmd.tick = 1'b1;
               default: ;
            endcase
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_FINISH;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (!stat.hit) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else if (stat.opcode == OP_UNREGISTER) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_MUL_Q;
            end
         end
         // Close the gap one entry at a time
         S_SHIFT_RD: begin
            if (stat.shift_end) begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_MUL_Q: begin
            cmd.mul_q = 1'b1;
            state_in  = S_MUL_INC;
         end
         S_MUL_INC: begin
            cmd.mul_inc = 1'b1;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.add_time   = 1'b1;
            cmd.sel_format = !stat.key_current;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### src/rtp_timestamp_clock_top.sv
// Top level of the RTP timestamp clock.
//
// RTP timestamp clock with a table of up to TABLE_DEPTH registered media formats. One
// request transaction is worked on at a time; the result register lets a new request be
// taken while the previous result still waits. Register, read-latest and tick requests
// go from decode straight to the finish state, which loads the result register. A
// timestamp request with the current key first passes through the reciprocal division
// of the rate by 1000, the increment multiply and the add. A lookup walks the table
// through its single registered read port with a read and a compare state per entry
// examined, and an unregister closes the gap with a read and a write state per entry
// moved. The entries examined and moved together cover the table once. Configuration
// writes take effect at once.
`default_nettype none

module rtp_timestamp_clock_top #(
   parameter int unsigned TABLE_DEPTH        = 8,
   parameter int unsigned IDLE_LIMIT_SECONDS = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rtc_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rtc_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);
   import rtc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rtc_dpath #(
      .TABLE_DEPTH        (TABLE_DEPTH),
      .IDLE_LIMIT_SECONDS (IDLE_LIMIT_SECONDS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### src/rtc_checker.sv
// Port-level checker of the RTP timestamp clock and its bind to the top level.
`default_nettype none

module rtc_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rtc_pkg::rsp_type rsp_payload
);
   import rtc_pkg::*;

   // A result waiting for the consumer holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A failed request carries neither timestamp nor key
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != ST_OK) |->
         (rsp_payload.timestamp == '0) && (rsp_payload.echoed_key == '0))
      else $error("error result with payload");

   // One request at a time: busy in the cycle after a request transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind rtp_timestamp_clock_top rtc_checker u_rtc_checker (.*);

`default_nettype wire
